// ===== rtl/core/sweep_tone_square_wave_generator_core_assert.svh =====
// ----------------------------------------------------------------------------
// sweep tone generator assertion macros
// property macros that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SWEEP_TONE_SQUARE_WAVE_GENERATOR_CORE_ASSERT_SVH
`define SWEEP_TONE_SQUARE_WAVE_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/stsqw_pkg.sv =====
// ----------------------------------------------------------------------------
// sweep tone generator package
// widths, register indexes, payload types and the tone table
// ----------------------------------------------------------------------------
package stsqw_pkg;

   localparam int DEF_NUM_TONES  = 7;
   localparam int DEF_TIMER_SPAN = 65536;

   localparam int CLK_HZ_W   = 27;
   localparam int DWELL_W    = 32;
   localparam int SET_W      = 17;
   localparam int CNT_W      = 16;
   localparam int TICKS_W    = 21;
   localparam int TONE_NUM_W = 3;
   localparam int TONE_IDX_W = 4;

   localparam int DIV_DVD_W = 28;
   localparam int DIV_DVS_W = 17;
   localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CORE_CLOCK_HZ = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_TICKS   = 4'd1;

   localparam logic [CLK_HZ_W-1:0] RST_CORE_CLOCK_HZ = 27'd24000000;
   localparam logic [DWELL_W-1:0]  RST_DWELL_TICKS   = 32'd48000000;

   localparam int TONE_TBL_LEN = 7;
   localparam int TONE_HZ_W    = 10;
   localparam logic [TONE_HZ_W-1:0] TONE_HZ [TONE_TBL_LEN] =
      '{10'd50, 10'd100, 10'd200, 10'd300, 10'd500, 10'd666, 10'd900};

   typedef struct packed {
      logic enable;
   } req_payload_type;

   typedef struct packed {
      logic                  pin_level;
      logic [TONE_NUM_W-1:0] tone_number;
      logic [SET_W-1:0]      prescale_value;
      logic [SET_W-1:0]      reload_value;
      logic                  update_event;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_DVD_W-1:0] dividend;
      logic [DIV_DVS_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_DVD_W-1:0] quotient;
   } div_sts_type;

   // twice the tone frequency, table wraps after seven entries
   function automatic logic [DIV_DVS_W-1:0] tone_divisor(input logic [TONE_IDX_W-1:0] idx);
      logic [TONE_IDX_W-1:0] m;
      if (idx >= TONE_IDX_W'(2 * TONE_TBL_LEN)) begin
         m = idx - TONE_IDX_W'(2 * TONE_TBL_LEN);
      end else if (idx >= TONE_IDX_W'(TONE_TBL_LEN)) begin
         m = idx - TONE_IDX_W'(TONE_TBL_LEN);
      end else begin
         m = idx;
      end
      return DIV_DVS_W'({TONE_HZ[m[2:0]], 1'b0});
   endfunction

endpackage

// ===== rtl/core/stsqw_stream_if.sv =====
// ----------------------------------------------------------------------------
// sweep tone generator stream interface
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface stsqw_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/sweep_tone_square_wave_generator_core.sv =====
// a tick accepted within a dwell lands in the output register in the next cycle
// throughput: one tick per cycle while the tone holds and the result output is not stalled
// a tick that ends a dwell waits for three serial divisions: ticks, prescale and reload;
// the first tick after reset waits for the same divisions and then takes its step
// reset: sweep at tone 0, counters and pin cleared, settings computed on first tick
// ----------------------------------------------------------------------------
// sweep tone square wave generator
// swept tone table, prescale and period counters driving a square wave pin
// ----------------------------------------------------------------------------
`include "sweep_tone_square_wave_generator_core_assert.svh"

module sweep_tone_square_wave_generator_core #(
   parameter int NUM_TONES  = stsqw_pkg::DEF_NUM_TONES,
   parameter int TIMER_SPAN = stsqw_pkg::DEF_TIMER_SPAN
) (
   input  logic                 clock,
   input  logic                 reset,
   stsqw_stream_if.sink         req_if,
   stsqw_stream_if.source       rsp_if,
   stsqw_stream_if.sink         csr_if
);

   import stsqw_pkg::*;

   localparam int TIDX_W    = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
   localparam int DWELL_X_W = DWELL_W + 1;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_LOAD_PRE  = 2'd1;
   localparam logic [1:0] ST_STEP      = 2'd2;
   localparam logic [1:0] ST_LOAD_POST = 2'd3;

   localparam logic [1:0] PH_TICKS = 2'd0;
   localparam logic [1:0] PH_PSC   = 2'd1;
   localparam logic [1:0] PH_ARR   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  ld_pend_ff, ld_pend_in;
   logic                  en_ff, en_in;
   logic                  upd_hold_ff, upd_hold_in;
   logic [TIDX_W-1:0]     tone_ff, tone_in;
   logic [DWELL_W-1:0]    dcnt_ff, dcnt_in;
   logic [SET_W-1:0]      psc_ff, psc_in;
   logic [SET_W-1:0]      arr_ff, arr_in;
   logic [TICKS_W-1:0]    ticks_ff, ticks_in;
   logic [CNT_W-1:0]      pc_ff, pc_in;
   logic [CNT_W-1:0]      per_ff, per_in;
   logic                  lvl_ff, lvl_in;
   logic                  run_ff, run_in;
   logic [CLK_HZ_W-1:0]   clk_hz_ff;
   logic [DWELL_W-1:0]    dwell_ff;
   logic                  rsp_vld_ff, rsp_vld_in;
   rsp_payload_type       rsp_ff, rsp_in;

   div_cmd_type           div_cmd;
   div_sts_type           div_sts;

   logic                  req_ready;
   logic                  req_acc;
   logic                  step_go;
   logic                  step_en;
   logic                  ld_start;
   logic                  ld_fin;
   logic                  rsp_wr;
   logic [TONE_IDX_W-1:0] tone_x_ff;
   logic [TONE_IDX_W-1:0] tone_x_in;

   logic [SET_W-1:0]      pc_inc;
   logic [SET_W-1:0]      per_inc;
   logic [DWELL_X_W-1:0]  dcnt_inc;
   logic [CNT_W-1:0]      st_pc;
   logic [CNT_W-1:0]      st_per;
   logic                  st_lvl;
   logic                  st_run;
   logic                  st_upd;
   logic                  st_wrap;
   logic [DWELL_W-1:0]    st_dcnt;
   logic [TIDX_W-1:0]     st_tone;

   logic [TICKS_W-1:0]    ticks_new;
   logic [SET_W-1:0]      psc_new;
   logic [SET_W-1:0]      arr_new;

   stsqw_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // handshakes
   assign req_ready     = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready  = req_ready;
   assign req_acc       = req_if.valid && req_ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_vld_ff;
   assign rsp_if.payload = rsp_ff;

   assign tone_x_ff = TONE_IDX_W'(tone_ff);
   assign tone_x_in = TONE_IDX_W'(tone_in);
   assign step_en   = (state_ff == ST_STEP) ? en_ff : req_if.payload.enable;

   // one tick of the timer and dwell counter
   assign pc_inc   = SET_W'(pc_ff) + SET_W'(1);
   assign per_inc  = SET_W'(per_ff) + SET_W'(1);
   assign dcnt_inc = DWELL_X_W'(dcnt_ff) + DWELL_X_W'(1);
   assign st_wrap  = dcnt_inc >= DWELL_X_W'(dwell_ff);
   assign st_dcnt  = st_wrap ? '0 : dcnt_inc[DWELL_W-1:0];
   assign st_tone  = (tone_ff == TIDX_W'(NUM_TONES - 1)) ? '0 : tone_ff + TIDX_W'(1);

   always_comb begin
      st_pc  = pc_ff;
      st_per = per_ff;
      st_lvl = lvl_ff;
      st_run = run_ff;
      st_upd = 1'b0;
      if (step_en) begin
         if (!run_ff) begin
            st_run = 1'b1;
            st_pc  = '0;
            st_per = '0;
         end else if (pc_inc >= psc_ff) begin
            st_pc = '0;
            if (per_inc >= arr_ff) begin
               st_per = '0;
               st_upd = 1'b1;
               st_lvl = !lvl_ff;
            end else begin
               st_per = per_inc[CNT_W-1:0];
            end
         end else begin
            st_pc = pc_inc[CNT_W-1:0];
         end
      end else begin
         st_run = 1'b0;
         st_lvl = 1'b0;
      end
   end

   // control
   always_comb begin
      state_in    = state_ff;
      ld_pend_in  = ld_pend_ff;
      en_in       = en_ff;
      upd_hold_in = upd_hold_ff;
      tone_in     = tone_ff;
      dcnt_in     = dcnt_ff;
      pc_in       = pc_ff;
      per_in      = per_ff;
      lvl_in      = lvl_ff;
      run_in      = run_ff;
      rsp_in      = rsp_ff;
      rsp_wr      = 1'b0;
      ld_start    = 1'b0;
      step_go     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (ld_pend_ff) begin
                  en_in    = req_if.payload.enable;
                  ld_start = 1'b1;
                  state_in = ST_LOAD_PRE;
               end else begin
                  step_go = 1'b1;
               end
            end
         end
         ST_LOAD_PRE: begin
            if (ld_fin) begin
               ld_pend_in = 1'b0;
               pc_in      = '0;
               per_in     = '0;
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            step_go = 1'b1;
         end
         ST_LOAD_POST: begin
            if (ld_fin) begin
               pc_in                 = '0;
               per_in                = '0;
               rsp_wr                = 1'b1;
               rsp_in.pin_level      = lvl_ff;
               rsp_in.tone_number    = tone_x_ff[TONE_NUM_W-1:0];
               rsp_in.prescale_value = psc_ff;
               rsp_in.reload_value   = arr_new;
               rsp_in.update_event   = upd_hold_ff;
               state_in              = ST_IDLE;
            end
         end
      endcase
      if (step_go) begin
         pc_in   = st_pc;
         per_in  = st_per;
         lvl_in  = st_lvl;
         run_in  = st_run;
         dcnt_in = st_dcnt;
         if (st_wrap) begin
            tone_in     = st_tone;
            upd_hold_in = st_upd;
            ld_start    = 1'b1;
            state_in    = ST_LOAD_POST;
         end else begin
            rsp_wr                = 1'b1;
            rsp_in.pin_level      = st_lvl;
            rsp_in.tone_number    = tone_x_ff[TONE_NUM_W-1:0];
            rsp_in.prescale_value = psc_ff;
            rsp_in.reload_value   = arr_ff;
            rsp_in.update_event   = st_upd;
            state_in              = ST_IDLE;
         end
      end
      rsp_vld_in = rsp_wr || (rsp_vld_ff && !rsp_if.ready);
   end

   // divider settings: ticks, then prescale, then reload
   assign ticks_new = (div_sts.quotient < DIV_DVD_W'(2)) ?
                      TICKS_W'(2) : div_sts.quotient[TICKS_W-1:0];
   assign psc_new   = (div_sts.quotient == '0) ?
                      SET_W'(1) : div_sts.quotient[SET_W-1:0];
   assign arr_new   = (div_sts.quotient < DIV_DVD_W'(2)) ?
                      SET_W'(2) : div_sts.quotient[SET_W-1:0];
   assign ld_fin    = div_sts.done && (phase_ff == PH_ARR);

   always_comb begin
      phase_in         = phase_ff;
      ticks_in         = ticks_ff;
      psc_in           = psc_ff;
      arr_in           = arr_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = DIV_DVD_W'(clk_hz_ff);
      div_cmd.divisor  = tone_divisor(tone_x_in);
      if (div_sts.done) begin
         unique case (phase_ff)
            PH_TICKS: begin
               ticks_in         = ticks_new;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DIV_DVD_W'(ticks_new) + DIV_DVD_W'(TIMER_SPAN - 1);
               div_cmd.divisor  = DIV_DVS_W'(TIMER_SPAN);
               phase_in         = PH_PSC;
            end
            PH_PSC: begin
               psc_in           = psc_new;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DIV_DVD_W'(ticks_ff);
               div_cmd.divisor  = psc_new;
               phase_in         = PH_ARR;
            end
            PH_ARR: begin
               arr_in = arr_new;
            end
            default: begin
               phase_in = PH_TICKS;
            end
         endcase
      end else if (ld_start) begin
         div_cmd.start = 1'b1;
         phase_in      = PH_TICKS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_TICKS;
         ld_pend_ff  <= 1'b1;
         tone_ff     <= '0;
         dcnt_ff     <= '0;
         pc_ff       <= '0;
         per_ff      <= '0;
         lvl_ff      <= 1'b0;
         run_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         clk_hz_ff   <= RST_CORE_CLOCK_HZ;
         dwell_ff    <= RST_DWELL_TICKS;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         ld_pend_ff  <= ld_pend_in;
         tone_ff     <= tone_in;
         dcnt_ff     <= dcnt_in;
         pc_ff       <= pc_in;
         per_ff      <= per_in;
         lvl_ff      <= lvl_in;
         run_ff      <= run_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_if.valid) begin
            if (csr_if.payload.index == CSR_CORE_CLOCK_HZ) begin
               clk_hz_ff <= csr_if.payload.data[CLK_HZ_W-1:0];
            end else if (csr_if.payload.index == CSR_DWELL_TICKS) begin
               dwell_ff <= csr_if.payload.data[DWELL_W-1:0];
            end
         end
      end
      en_ff       <= en_in;
      upd_hold_ff <= upd_hold_in;
      ticks_ff    <= ticks_in;
      psc_ff      <= psc_in;
      arr_ff      <= arr_in;
      rsp_ff      <= rsp_in;
   end

   `SQ_ASSERT_IMP(a_rsp_settings, clock, reset, rsp_vld_ff, (rsp_ff.prescale_value != '0) && (rsp_ff.reload_value >= SET_W'(2)), "result carries prescale below one or reload below two")
   `SQ_ASSERT_IMP(a_div_in_load, clock, reset, div_sts.busy, (state_ff == ST_LOAD_PRE) || (state_ff == ST_LOAD_POST), "divider busy outside a settings load")
   `SQ_ASSERT_IMP(a_tone_range, clock, reset, 1'b1, tone_ff <= TIDX_W'(NUM_TONES - 1), "tone index past end of sweep")
   `SQ_ASSERT_IMP(a_cnt_range, clock, reset, !ld_pend_ff && (state_ff == ST_IDLE), (SET_W'(pc_ff) < psc_ff) && (SET_W'(per_ff) < arr_ff), "timer counter beyond its setting")
   `SQ_ASSERT_NXT(a_post_load_rsp, clock, reset, (state_ff == ST_LOAD_POST) && ld_fin, rsp_vld_ff, "no result after tone change load")

endmodule

// ===== rtl/core/stsqw_div.sv =====
// ----------------------------------------------------------------------------
// sweep tone generator serial divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stsqw_div (
   input  logic                  clock,
   input  logic                  reset,
   input  stsqw_pkg::div_cmd_type cmd,
   output stsqw_pkg::div_sts_type sts
);

   import stsqw_pkg::*;

   logic [DIV_DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_DVS_W-1:0] dvs_ff, dvs_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DVS_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cnt_ff != '0) begin
         if (fits) begin
            rem_in = DIV_DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DIV_DVS_W-1:0];
         end
         quo_in  = {quo_ff[DIV_DVD_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = cnt_ff == DIV_CNT_W'(1);
      end else if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
         cnt_in = DIV_CNT_W'(DIV_DVD_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign sts.busy     = cnt_ff != '0;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule
